FILE: rtl/core/esat_pkg.sv
// Shared types, codes and constants of the edge suppression and threshold block.
package esat_pkg;

	// Fixed field widths
	localparam int MAG_BITS  = 15;
	localparam int MAG_MAX   = (1 << MAG_BITS) - 1;
	localparam int GRAD_BITS = 16;
	localparam int FW_BITS   = 10;
	localparam int HGT_BITS  = 13;

	// Geometry limits and register reset values
	localparam int SIZE_MIN     = 3;
	localparam int HEIGHT_MAX   = 4096;
	localparam int LOW_RESET    = 4500;
	localparam int HIGH_RESET   = 5000;
	localparam int WIDTH_RESET  = 396;
	localparam int HEIGHT_RESET = 400;

	// Depth of the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// Direction sectors
	typedef logic [1:0] sector_t;
	localparam sector_t SEC_0   = 2'd0;
	localparam sector_t SEC_45  = 2'd1;
	localparam sector_t SEC_90  = 2'd2;
	localparam sector_t SEC_135 = 2'd3;

	// Edge classes
	typedef logic [1:0] class_t;
	localparam class_t CLS_NONE   = 2'd0;
	localparam class_t CLS_WEAK   = 2'd1;
	localparam class_t CLS_STRONG = 2'd2;

	// Register indexes
	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_LOW_LEVEL    = 2'd0;
	localparam reg_idx_t REG_HIGH_LEVEL   = 2'd1;
	localparam reg_idx_t REG_FRAME_WIDTH  = 2'd2;
	localparam reg_idx_t REG_FRAME_HEIGHT = 2'd3;

	// Position of the answered center pixel, worked out by the front
	typedef struct packed {
		logic has_result;
		logic top;
		logic bottom;
		logic left;
		logic right;
		logic last;
	} pos_flags_t;

	// One classified item as it travels from front to back
	typedef struct packed {
		logic [MAG_BITS-1:0] mag;
		sector_t             sec;
		pos_flags_t          flags;
	} item_t;

endpackage

FILE: rtl/core/edge_suppress_and_threshold.sv
// Top level: configuration registers, front, queue and back of the edge suppressor.
//
// Pixel channel (pix_valid/pix_stall): one transaction per pixel in raster order,
// signed grad_horiz/grad_vert; drain marks a transaction that carries no pixel.
// Result channel (res_valid/res_stall): kept_magnitude after non-maximum suppression,
// edge_class (none/weak/strong) and frame_last on the final pixel of a frame.
// The pixel at raster position q is answered by the transaction at q+frame_width+1;
// after the last pixel, frame_width+1 drain transactions flush the frame. Drains
// sent while pixels are still due are taken and dropped.
// Throughput: one transaction per cycle in both directions when nothing stalls. Between
// taking the answering transaction and presenting its result lie 2 front stages
// (abs/add, squares), the queue, the row buffer read, the window stage and the output
// register.
// When res_stall is high the result holds; the 4-entry queue and the pipeline
// fill before pix_stall rises.
// Reset: thresholds 4500/5000, geometry 396x400, position at frame start. The row
// buffer RAM is not cleared: entries not yet written this frame only feed rows
// above the image, which never take part. Writing frame_width or frame_height
// restarts the frame; write registers only while the block is idle.
module edge_suppress_and_threshold
	import esat_pkg::*;
#(
	parameter int MAX_WIDTH = 512
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [3:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        pix_valid,
	output logic                        pix_stall,
	input  logic signed [GRAD_BITS-1:0] grad_horiz,
	input  logic signed [GRAD_BITS-1:0] grad_vert,
	input  logic                        drain,
	output logic                        res_valid,
	input  logic                        res_stall,
	output logic [MAG_BITS-1:0]         kept_magnitude,
	output logic [1:0]                  edge_class,
	output logic                        frame_last
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int QW = CW + $bits(item_t);
	localparam int EFF_W_RESET = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;

	logic [MAG_BITS-1:0] low_q;
	logic [MAG_BITS-1:0] high_q;
	logic [FW_BITS-1:0]  width_q;
	logic [HGT_BITS-1:0] height_q;
	logic [WW-1:0]       eff_width_q;
	logic [HGT_BITS-1:0] eff_height_q;

	reg_idx_t            reg_idx;
	logic                cfg_wr;
	logic                restart;
	logic [FW_BITS-1:0]  width_in;
	logic [HGT_BITS-1:0] height_in;
	logic [WW-1:0]       eff_width_in;
	logic [HGT_BITS-1:0] eff_height_in;

	logic                push;
	logic                pop;
	logic                q_full;
	logic                q_empty;
	logic [CW-1:0]       push_col;
	item_t               push_item;
	logic [QW-1:0]       push_data;
	logic [QW-1:0]       pop_data;
	logic [CW-1:0]       pop_col;
	item_t               pop_item;

	// Decode register writes
	assign pready    = 1'b1;
	assign reg_idx   = reg_idx_t'(paddr[3:2]);
	assign cfg_wr    = psel && penable && pwrite && pready;
	assign restart   = cfg_wr && ((reg_idx == REG_FRAME_WIDTH) || (reg_idx == REG_FRAME_HEIGHT));
	assign width_in  = pwdata[FW_BITS-1:0];
	assign height_in = pwdata[HGT_BITS-1:0];

	// Clamp geometry as it is written
	always_comb begin
		if (width_in < FW_BITS'(SIZE_MIN)) begin
			eff_width_in = WW'(SIZE_MIN);
		end else if (32'(width_in) > MAX_WIDTH) begin
			eff_width_in = WW'(MAX_WIDTH);
		end else begin
			eff_width_in = WW'(width_in);
		end
		if (height_in < HGT_BITS'(SIZE_MIN)) begin
			eff_height_in = HGT_BITS'(SIZE_MIN);
		end else if (height_in > HGT_BITS'(HEIGHT_MAX)) begin
			eff_height_in = HGT_BITS'(HEIGHT_MAX);
		end else begin
			eff_height_in = height_in;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q        <= MAG_BITS'(LOW_RESET);
			high_q       <= MAG_BITS'(HIGH_RESET);
			width_q      <= FW_BITS'(WIDTH_RESET);
			height_q     <= HGT_BITS'(HEIGHT_RESET);
			eff_width_q  <= WW'(EFF_W_RESET);
			eff_height_q <= HGT_BITS'(HEIGHT_RESET);
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_LOW_LEVEL:  low_q  <= pwdata[MAG_BITS-1:0];
				REG_HIGH_LEVEL: high_q <= pwdata[MAG_BITS-1:0];
				REG_FRAME_WIDTH: begin
					width_q     <= width_in;
					eff_width_q <= eff_width_in;
				end
				REG_FRAME_HEIGHT: begin
					height_q     <= height_in;
					eff_height_q <= eff_height_in;
				end
				default: begin
				end
			endcase
		end
	end

	// Register read back
	always_comb begin
		case (reg_idx)
			REG_LOW_LEVEL:    prdata = 32'(low_q);
			REG_HIGH_LEVEL:   prdata = 32'(high_q);
			REG_FRAME_WIDTH:  prdata = 32'(width_q);
			REG_FRAME_HEIGHT: prdata = 32'(height_q);
			default:          prdata = '0;
		endcase
	end

	esat_front #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.restart    (restart),
		.eff_width  (eff_width_q),
		.eff_height (eff_height_q),
		.pix_valid  (pix_valid),
		.pix_stall  (pix_stall),
		.grad_horiz (grad_horiz),
		.grad_vert  (grad_vert),
		.drain      (drain),
		.q_full     (q_full),
		.push       (push),
		.push_col   (push_col),
		.push_item  (push_item)
	);

	assign push_data = {push_col, push_item};
	assign pop_col   = pop_data[QW-1 -: CW];
	assign pop_item  = item_t'(pop_data[$bits(item_t)-1:0]);

	esat_queue #(
		.WIDTH (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (q_empty)
	);

	esat_back #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.low_level      (low_q),
		.high_level     (high_q),
		.q_empty        (q_empty),
		.pop            (pop),
		.pop_col        (pop_col),
		.pop_item       (pop_item),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.kept_magnitude (kept_magnitude),
		.edge_class     (edge_class),
		.frame_last     (frame_last)
	);

endmodule

FILE: rtl/core/esat_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module esat_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port, data holds while no read is issued
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: rtl/core/esat_front.sv
// Front: accepts gradient transactions, tracks raster position, forms magnitude and sector.
module esat_front
	import esat_pkg::*;
#(
	parameter int MAX_WIDTH = 512
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              restart,
	input  logic [$clog2(MAX_WIDTH+1)-1:0]    eff_width,
	input  logic [HGT_BITS-1:0]               eff_height,
	input  logic                              pix_valid,
	output logic                              pix_stall,
	input  logic signed [GRAD_BITS-1:0]       grad_horiz,
	input  logic signed [GRAD_BITS-1:0]       grad_vert,
	input  logic                              drain,
	input  logic                              q_full,
	output logic                              push,
	output logic [$clog2(MAX_WIDTH)-1:0]      push_col,
	output item_t                             push_item
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);

	logic [CW-1:0]       col_q;
	logic [HGT_BITS-1:0] row_q;
	logic [CW-1:0]       col_cur;
	logic [HGT_BITS-1:0] row_cur;
	logic [WW-1:0]       col_inc;
	logic [HGT_BITS-1:0] row_inc;
	logic [HGT_BITS-1:0] hgt_inc;
	logic                col_zero;
	logic                flush;
	logic                accept;
	logic                keep;
	pos_flags_t          flags_cur;
	logic [GRAD_BITS-1:0] ax_in;
	logic [GRAD_BITS-1:0] ay_in;
	logic                same_in;

	logic                v_s1;
	logic [GRAD_BITS-1:0] ax_s1;
	logic [GRAD_BITS-1:0] ay_s1;
	logic                same_s1;
	logic [CW-1:0]       col_s1;
	pos_flags_t          flags_s1;

	logic [GRAD_BITS:0]   sum_abs;
	logic [GRAD_BITS-1:0] diff_abs;

	logic                    v_s2;
	logic [2*GRAD_BITS+1:0]  sum_sq_s2;
	logic [2*GRAD_BITS-1:0]  diff_sq_s2;
	logic [2*GRAD_BITS-1:0]  ax_sq_s2;
	logic                    zero_s2;
	logic                    gt_s2;
	logic                    same_s2;
	logic [MAG_BITS-1:0]     mag_s2;
	logic [CW-1:0]           col_s2;
	pos_flags_t              flags_s2;

	logic [2*GRAD_BITS:0]    twice_ax_sq;
	sector_t                 sec;
	logic                    s1_ready;
	logic                    s2_ready;
	logic                    adv_s1;

	// Work out the position of this transaction and of the center it answers
	always_comb begin
		col_cur  = (WW'(col_q) >= eff_width) ? '0 : col_q;
		hgt_inc  = eff_height + 1'b1;
		row_cur  = (row_q > hgt_inc) ? '0 : row_q;
		col_zero = (col_cur == '0);
		col_inc  = WW'(col_cur) + 1'b1;
		row_inc  = row_cur + 1'b1;
		flush    = (row_cur >= eff_height);
		if (col_zero) begin
			flags_cur.has_result = (row_cur >= HGT_BITS'(2)) && (row_cur <= hgt_inc);
			flags_cur.top        = (row_cur == HGT_BITS'(2));
			flags_cur.bottom     = (row_cur == hgt_inc);
		end else begin
			flags_cur.has_result = (row_cur >= HGT_BITS'(1)) && (row_cur <= eff_height);
			flags_cur.top        = (row_cur == HGT_BITS'(1));
			flags_cur.bottom     = (row_cur == eff_height);
		end
		flags_cur.left  = (col_cur == CW'(1));
		flags_cur.right = col_zero;
		flags_cur.last  = col_zero && (row_cur == hgt_inc);
	end

	// Absolute gradients, discarded in flush slots
	always_comb begin
		ax_in   = grad_horiz[GRAD_BITS-1] ? $unsigned(-grad_horiz) : $unsigned(grad_horiz);
		ay_in   = grad_vert[GRAD_BITS-1] ? $unsigned(-grad_vert) : $unsigned(grad_vert);
		same_in = ((!grad_horiz[GRAD_BITS-1]) && (grad_horiz != '0)) ==
			((!grad_vert[GRAD_BITS-1]) && (grad_vert != '0));
		if (flush) begin
			ax_in = '0;
			ay_in = '0;
		end
	end

	// Handshake: a drain before the frame is complete is taken and dropped
	assign s2_ready  = !v_s2 || !q_full;
	assign s1_ready  = !v_s1 || s2_ready;
	assign adv_s1    = v_s1 && s2_ready;
	assign pix_stall = !s1_ready;
	assign accept    = pix_valid && !pix_stall;
	assign keep      = accept && (!drain || flush);

	// Advance the raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (keep) begin
			if (flags_cur.has_result && flags_cur.last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_inc >= eff_width) begin
				col_q <= '0;
				row_q <= row_inc;
			end else begin
				col_q <= col_inc[CW-1:0];
				row_q <= row_cur;
			end
		end
	end

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (keep) begin
				v_s1 <= 1'b1;
			end else if (adv_s1) begin
				v_s1 <= 1'b0;
			end
			if (adv_s1) begin
				v_s2 <= 1'b1;
			end else if (push) begin
				v_s2 <= 1'b0;
			end
		end
	end

	// Stage 1: hold absolute gradients and position
	always_ff @(posedge clk) begin
		if (keep) begin
			ax_s1    <= ax_in;
			ay_s1    <= ay_in;
			same_s1  <= same_in;
			col_s1   <= col_cur;
			flags_s1 <= flags_cur;
		end
	end

	assign sum_abs  = {1'b0, ax_s1} + {1'b0, ay_s1};
	assign diff_abs = ay_s1 - ax_s1;

	// Stage 2: squares for the tangent tests, saturated magnitude
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			sum_sq_s2  <= sum_abs * sum_abs;
			diff_sq_s2 <= diff_abs * diff_abs;
			ax_sq_s2   <= ax_s1 * ax_s1;
			zero_s2    <= (ax_s1 == '0) && (ay_s1 == '0);
			gt_s2      <= (ay_s1 > ax_s1);
			same_s2    <= same_s1;
			mag_s2     <= (sum_abs > (GRAD_BITS+1)'(MAG_MAX)) ? MAG_BITS'(MAG_MAX)
				: sum_abs[MAG_BITS-1:0];
			col_s2     <= col_s1;
			flags_s2   <= flags_s1;
		end
	end

	// Quantize direction: below 22.5, above 67.5, else by gradient signs
	always_comb begin
		twice_ax_sq = {ax_sq_s2, 1'b0};
		if (zero_s2) begin
			sec = SEC_0;
		end else if (sum_sq_s2 < (2*GRAD_BITS+2)'(twice_ax_sq)) begin
			sec = SEC_0;
		end else if (gt_s2 && ((2*GRAD_BITS+1)'(diff_sq_s2) > twice_ax_sq)) begin
			sec = SEC_90;
		end else if (same_s2) begin
			sec = SEC_45;
		end else begin
			sec = SEC_135;
		end
	end

	assign push            = v_s2 && !q_full;
	assign push_col        = col_s2;
	assign push_item.mag   = mag_s2;
	assign push_item.sec   = sec;
	assign push_item.flags = flags_s2;

	// Column position stays inside the row in use
	assert property (@(posedge clk) disable iff (!arst_n) WW'(col_q) < eff_width)
		else $error("column position outside the frame width");

endmodule

FILE: rtl/core/esat_queue.sv
// Small flop queue that decouples the front from the back.
module esat_queue #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [NW-1:0]    count_q;

	assign full     = (count_q == NW'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = slot_q[rd_ptr_q];

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Front never pushes into a full queue, back never pops an empty one
	assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("push into full queue");
	assert property (@(posedge clk) disable iff (!arst_n) !(pop && empty))
		else $error("pop from empty queue");

endmodule

FILE: rtl/core/esat_back.sv
// Back: line buffers, 3x3 window, suppression along the sector and threshold classing.
module esat_back
	import esat_pkg::*;
#(
	parameter int MAX_WIDTH = 512
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [MAG_BITS-1:0]          low_level,
	input  logic [MAG_BITS-1:0]          high_level,
	input  logic                         q_empty,
	output logic                         pop,
	input  logic [$clog2(MAX_WIDTH)-1:0] pop_col,
	input  item_t                        pop_item,
	output logic                         res_valid,
	input  logic                         res_stall,
	output logic [MAG_BITS-1:0]          kept_magnitude,
	output logic [1:0]                   edge_class,
	output logic                         frame_last
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = 2 * MAG_BITS + 2;

	logic                v_s1;
	item_t               item_s1;
	logic [CW-1:0]       col_s1;

	logic [RW-1:0]       rd_word;
	logic [RW-1:0]       wr_word;
	logic [MAG_BITS-1:0] rd_r1;
	logic [MAG_BITS-1:0] rd_r2;
	sector_t             rd_sec;

	// Window columns c-1 and c of rows r-2, r-1, r; column c+1 comes from the read word and stage 1
	logic [MAG_BITS-1:0] win_q [3][2];
	sector_t             sec_dly_q;

	logic [MAG_BITS-1:0] nbr1;
	logic [MAG_BITS-1:0] nbr2;
	logic                use1;
	logic                use2;

	logic                v_s2;
	logic [MAG_BITS-1:0] center_s2;
	logic [MAG_BITS-1:0] nbr1_s2;
	logic [MAG_BITS-1:0] nbr2_s2;
	logic                use1_s2;
	logic                use2_s2;
	logic                has_s2;
	logic                last_s2;

	logic [MAG_BITS-1:0] kept;
	class_t              cls;
	logic                res_valid_q;
	logic [MAG_BITS-1:0] kept_q;
	class_t              cls_q;
	logic                last_q;

	logic                out_free;
	logic                out_load;
	logic                adv_s2;
	logic                s2_ready;
	logic                adv_s1;

	// Flow control
	assign out_free = !res_valid_q || !res_stall;
	assign adv_s2   = v_s2 && (!has_s2 || out_free);
	assign out_load = adv_s2 && has_s2;
	assign s2_ready = !v_s2 || adv_s2;
	assign adv_s1   = v_s1 && s2_ready;
	assign pop      = !q_empty && (!v_s1 || adv_s1);

	// Row buffer word: sector of row r-1, magnitude of row r-2, magnitude of row r-1.
	// Entries read before being written only feed off-image rows, which are masked.
	// The one address read and written in the same cycle is column zero at frame
	// restart, where the read serves rows above the image.
	assign rd_r1   = rd_word[MAG_BITS-1:0];
	assign rd_r2   = rd_word[2*MAG_BITS-1:MAG_BITS];
	assign rd_sec  = rd_word[RW-1:2*MAG_BITS];
	assign wr_word = {item_s1.sec, rd_r1, item_s1.mag};

	esat_ram #(
		.WIDTH (RW),
		.DEPTH (MAX_WIDTH)
	) u_rows (
		.clk     (clk),
		.wr_en   (adv_s1),
		.wr_addr (col_s1),
		.wr_data (wr_word),
		.rd_en   (pop),
		.rd_addr (pop_col),
		.rd_data (rd_word)
	);

	// Stage 1: hold the popped entry while its row buffer read completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (pop) begin
			v_s1 <= 1'b1;
		end else if (adv_s1) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_s1 <= pop_item;
			col_s1  <= pop_col;
		end
	end

	// Pick the two neighbours along the center's sector, drop off-image ones
	always_comb begin
		case (sec_dly_q)
			SEC_0: begin
				nbr1 = win_q[1][0];
				use1 = !item_s1.flags.left;
				nbr2 = rd_r1;
				use2 = !item_s1.flags.right;
			end
			SEC_45: begin
				nbr1 = win_q[0][0];
				use1 = !(item_s1.flags.top || item_s1.flags.left);
				nbr2 = item_s1.mag;
				use2 = !(item_s1.flags.bottom || item_s1.flags.right);
			end
			SEC_90: begin
				nbr1 = win_q[0][1];
				use1 = !item_s1.flags.top;
				nbr2 = win_q[2][1];
				use2 = !item_s1.flags.bottom;
			end
			default: begin
				nbr1 = rd_r2;
				use1 = !(item_s1.flags.top || item_s1.flags.right);
				nbr2 = win_q[2][0];
				use2 = !(item_s1.flags.bottom || item_s1.flags.left);
			end
		endcase
	end

	// Shift the window and the sector delay, load stage 2
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			win_q[0][0] <= win_q[0][1];
			win_q[1][0] <= win_q[1][1];
			win_q[2][0] <= win_q[2][1];
			win_q[0][1] <= rd_r2;
			win_q[1][1] <= rd_r1;
			win_q[2][1] <= item_s1.mag;
			sec_dly_q   <= rd_sec;
			center_s2   <= win_q[1][1];
			nbr1_s2     <= nbr1;
			nbr2_s2     <= nbr2;
			use1_s2     <= use1;
			use2_s2     <= use2;
			has_s2      <= item_s1.flags.has_result;
			last_s2     <= item_s1.flags.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s1) begin
			v_s2 <= 1'b1;
		end else if (adv_s2) begin
			v_s2 <= 1'b0;
		end
	end

	// Suppress against larger neighbours, then class against the thresholds
	always_comb begin
		if ((use1_s2 && (nbr1_s2 > center_s2)) || (use2_s2 && (nbr2_s2 > center_s2))) begin
			kept = '0;
		end else begin
			kept = center_s2;
		end
		if (kept >= high_level) begin
			cls = CLS_STRONG;
		end else if (kept >= low_level) begin
			cls = CLS_WEAK;
		end else begin
			cls = CLS_NONE;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			kept_q <= kept;
			cls_q  <= cls;
			last_q <= last_s2;
		end
	end

	assign res_valid      = res_valid_q;
	assign kept_magnitude = kept_q;
	assign edge_class     = cls_q;
	assign frame_last     = last_q;

	// A stalled result is never overwritten
	assert property (@(posedge clk) disable iff (!arst_n) !(out_load && res_valid_q && res_stall))
		else $error("output register overwritten while stalled");

endmodule
